[design/tbc_pkg.sv]
package tbc_pkg;

    localparam int unsigned ENTRIES_DEF   = 1024;
    localparam int unsigned ADDR_BITS_DEF = 48;

    localparam logic [1:0] KIND_LOOKUP    = 2'd0;
    localparam logic [1:0] KIND_TRANSLATE = 2'd1;
    localparam logic [1:0] KIND_FLUSH     = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] source_addr;
        logic [47:0] target_addr;
        logic [12:0] code_bytes;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [47:0] found_target;
        logic [31:0] use_count;
        logic        inserted;
        logic        table_full;
        logic [31:0] hits_so_far;
        logic [31:0] misses_so_far;
    } t_rsp;

endpackage

[design/translation_block_cache_core.sv]
// Channel   Ports                     Direction  Handshake
// request   i_req (tbc_pkg::t_req)    in         taken when start is high and busy is low
// result    o_rsp (tbc_pkg::t_rsp)    out        shown for one cycle while o_valid is high
//
// A lookup or translate item reads the tag memory one entry per cycle, from entry 0 up to
// and including the first match (all filled entries on a miss, and one entry on an empty
// table); its result is registered once that search ends.
// A flush or an unused kind gives its result in the cycle after acceptance.
// Reset empties the table and clears both counters; the entry memories are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module translation_block_cache_core #(
    parameter int unsigned ENTRIES   = tbc_pkg::ENTRIES_DEF,
    parameter int unsigned ADDR_BITS = tbc_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tbc_pkg::t_req i_req,
    output logic          o_valid,
    output tbc_pkg::t_rsp o_rsp
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [ADDR_BITS-1:0] mem_tag [ENTRIES];
    logic [ADDR_BITS-1:0] mem_tgt [ENTRIES];
    logic [12:0]          mem_len [ENTRIES];
    logic [31:0]          mem_cnt [ENTRIES];

    logic [ADDR_BITS-1:0] r_tag_q;
    logic [ADDR_BITS-1:0] r_tgt_q;
    logic [31:0]          r_cnt_q;

    logic                 r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [31:0]          r_hits, n_hits;
    logic [31:0]          r_misses, n_misses;
    logic [1:0]           r_kind;
    logic [ADDR_BITS-1:0] r_key;
    logic [ADDR_BITS-1:0] r_tgt_in;
    logic [12:0]          r_len;
    logic                 r_out_vld, n_out_vld;
    tbc_pkg::t_rsp        r_out, n_out;

    logic                 w_accept;
    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_ins_en;
    logic                 w_cnt_wr_en;
    logic [IDX_W-1:0]     w_cnt_wr_addr;
    logic [31:0]          w_cnt_wr_data;
    logic                 w_match;
    logic                 w_last;
    logic [31:0]          w_cnt_inc;

    assign w_accept  = start && !busy;
    assign w_match   = (r_fill != '0) && (r_tag_q == r_key);
    assign w_last    = (r_fill == '0) || ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);
    assign w_cnt_inc = r_cnt_q + 32'd1;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_fill        = r_fill;
        n_hits        = r_hits;
        n_misses      = r_misses;
        n_out_vld     = 1'b0;
        n_out         = r_out;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_idx + IDX_W'(1);
        w_ins_en      = 1'b0;
        w_cnt_wr_en   = 1'b0;
        w_cnt_wr_addr = r_idx;
        w_cnt_wr_data = w_cnt_inc;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.kind == tbc_pkg::KIND_LOOKUP ||
                        i_req.kind == tbc_pkg::KIND_TRANSLATE) begin
                        n_state   = S_SCAN;
                        n_idx     = '0;
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                    end else begin
                        if (i_req.kind == tbc_pkg::KIND_FLUSH) begin
                            n_fill = '0;
                        end
                        n_out_vld           = 1'b1;
                        n_out               = '0;
                        n_out.table_full    = (i_req.kind != tbc_pkg::KIND_FLUSH) &&
                                              (r_fill == CNT_W'(ENTRIES));
                        n_out.hits_so_far   = r_hits;
                        n_out.misses_so_far = r_misses;
                    end
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    w_cnt_wr_en        = 1'b1;
                    n_hits             = (r_kind == tbc_pkg::KIND_TRANSLATE) ?
                                         r_hits + 32'd1 : r_hits;
                    n_state            = S_IDLE;
                    n_out_vld          = 1'b1;
                    n_out              = '0;
                    n_out.hit          = 1'b1;
                    n_out.found_target = 48'(r_tgt_q);
                    n_out.use_count    = w_cnt_inc;
                    n_out.table_full   = (r_fill == CNT_W'(ENTRIES));
                    n_out.hits_so_far  = n_hits;
                    n_out.misses_so_far = r_misses;
                end else if (w_last) begin
                    n_out = '0;
                    if (r_kind == tbc_pkg::KIND_TRANSLATE) begin
                        n_misses = r_misses + 32'd1;
                        if (r_fill != CNT_W'(ENTRIES)) begin
                            w_ins_en       = 1'b1;
                            w_cnt_wr_en    = 1'b1;
                            w_cnt_wr_addr  = r_fill[IDX_W-1:0];
                            w_cnt_wr_data  = '0;
                            n_fill         = r_fill + CNT_W'(1);
                            n_out.inserted = 1'b1;
                        end
                    end
                    n_state             = S_IDLE;
                    n_out_vld           = 1'b1;
                    n_out.table_full    = (n_fill == CNT_W'(ENTRIES));
                    n_out.hits_so_far   = r_hits;
                    n_out.misses_so_far = n_misses;
                end else begin
                    w_rd_en = 1'b1;
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_tag_q <= mem_tag[w_rd_addr];
            r_tgt_q <= mem_tgt[w_rd_addr];
            r_cnt_q <= mem_cnt[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_en) begin
            mem_tag[r_fill[IDX_W-1:0]] <= r_key;
            mem_tgt[r_fill[IDX_W-1:0]] <= r_tgt_in;
            mem_len[r_fill[IDX_W-1:0]] <= r_len;
        end
        if (w_cnt_wr_en) begin
            mem_cnt[w_cnt_wr_addr] <= w_cnt_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_fill    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_fill    <= n_fill;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_kind   <= i_req.kind;
            r_key    <= ADDR_BITS'(i_req.source_addr);
            r_tgt_in <= ADDR_BITS'(i_req.target_addr);
            r_len    <= i_req.code_bytes;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRIES))
        else $error("fill level beyond table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.inserted |-> !o_rsp.hit && (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("insert without fill growth");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.kind == tbc_pkg::KIND_FLUSH |=> o_valid && r_fill == '0)
        else $error("flush did not empty the table");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && n_state == S_IDLE |=> o_valid && !busy)
        else $error("search ended without a result");

endmodule

[tb/sv/testbench.sv]
module testbench;

    localparam int unsigned ENTRIES     = tbc_pkg::ENTRIES_DEF;
    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    tbc_pkg::t_req i_req;
    logic          o_valid;
    tbc_pkg::t_rsp o_rsp;

    translation_block_cache_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    class block_cache_tracker;
        logic [47:0]   tag_mem    [ENTRIES];
        logic [47:0]   target_mem [ENTRIES];
        logic [12:0]   length_mem [ENTRIES];
        logic [31:0]   count_mem  [ENTRIES];
        int unsigned   fill_level;
        logic [31:0]   hit_total;
        logic [31:0]   miss_total;
        tbc_pkg::t_rsp pending_rsps[$];
        int unsigned   errors;

        function new();
            fill_level = 0;
            hit_total  = '0;
            miss_total = '0;
            errors     = 0;
        endfunction

        function void note_request(tbc_pkg::t_req r);
            tbc_pkg::t_rsp want;
            int unsigned   idx;
            want = '0;
            if (r.kind == tbc_pkg::KIND_LOOKUP || r.kind == tbc_pkg::KIND_TRANSLATE) begin
                for (idx = 0; idx < fill_level && !want.hit; idx++) begin
                    if (tag_mem[idx] == r.source_addr) begin
                        count_mem[idx]    = count_mem[idx] + 32'd1;
                        want.hit          = 1'b1;
                        want.found_target = target_mem[idx];
                        want.use_count    = count_mem[idx];
                    end
                end
                if (r.kind == tbc_pkg::KIND_TRANSLATE) begin
                    if (want.hit) begin
                        hit_total = hit_total + 32'd1;
                    end else begin
                        miss_total = miss_total + 32'd1;
                        if (fill_level < ENTRIES) begin
                            tag_mem[fill_level]    = r.source_addr;
                            target_mem[fill_level] = r.target_addr;
                            length_mem[fill_level] = r.code_bytes;
                            count_mem[fill_level]  = '0;
                            fill_level++;
                            want.inserted = 1'b1;
                        end
                    end
                end
            end else if (r.kind == tbc_pkg::KIND_FLUSH) begin
                fill_level = 0;
            end
            want.table_full    = (fill_level >= ENTRIES);
            want.hits_so_far   = hit_total;
            want.misses_so_far = miss_total;
            pending_rsps.push_back(want);
        endfunction

        function void check_result(tbc_pkg::t_rsp got);
            tbc_pkg::t_rsp want;
            if (pending_rsps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %p", got);
                return;
            end
            want = pending_rsps.pop_front();
            if (got.hit !== want.hit || got.found_target !== want.found_target ||
                got.use_count !== want.use_count || got.inserted !== want.inserted ||
                got.table_full !== want.table_full ||
                got.hits_so_far !== want.hits_so_far ||
                got.misses_so_far !== want.misses_so_far) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: hit=%0d tgt=%h cnt=%0d ins=%0d full=%0d h=%0d m=%0d",
                             want.hit, want.found_target, want.use_count, want.inserted,
                             want.table_full, want.hits_so_far, want.misses_so_far);
                    $display("         got: hit=%0d tgt=%h cnt=%0d ins=%0d full=%0d h=%0d m=%0d",
                             got.hit, got.found_target, got.use_count, got.inserted,
                             got.table_full, got.hits_so_far, got.misses_so_far);
                end
            end
        endfunction
    endclass

    block_cache_tracker tracker;
    bit                 idle_en;
    int unsigned        cycle_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            tracker.check_result(o_rsp);
    end

    function automatic logic [47:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic logic [47:0] pick_key(int unsigned pct_known);
        if (tracker.fill_level > 0 && $urandom_range(0, 99) < pct_known)
            return tracker.tag_mem[$urandom_range(0, tracker.fill_level - 1)];
        return rand_addr();
    endfunction

    task automatic issue(tbc_pkg::t_req r);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 99) < 18) begin
            start = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy);
        tracker.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send(logic [1:0] kind, logic [47:0] src, logic [47:0] tgt,
                        logic [12:0] len);
        tbc_pkg::t_req r;
        r.kind        = kind;
        r.source_addr = src;
        r.target_addr = tgt;
        r.code_bytes  = len;
        issue(r);
    endtask

    task automatic drain();
        start = 1'b0;
        while (tracker.pending_rsps.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_item();
        int unsigned sel;
        logic [1:0]  kind;
        logic [47:0] src;
        sel = $urandom_range(0, 99);
        if (tracker.fill_level > 64 && $urandom_range(0, 3) == 0)
            sel = 95;
        if (sel < 50) begin
            kind = tbc_pkg::KIND_TRANSLATE;
            src  = pick_key(50);
        end else if (sel < 94) begin
            kind = tbc_pkg::KIND_LOOKUP;
            src  = pick_key(75);
        end else if (sel < 97) begin
            kind = tbc_pkg::KIND_FLUSH;
            src  = rand_addr();
        end else begin
            kind = KIND_UNUSED;
            src  = pick_key(50);
        end
        send(kind, src, rand_addr(), 13'($urandom_range(0, 8191)));
    endtask

    initial begin
        tracker     = new();
        cycle_count = 0;
        idle_en     = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send(tbc_pkg::KIND_LOOKUP, '0, '0, '0);
        send(tbc_pkg::KIND_TRANSLATE, '0, '0, '0);
        send(tbc_pkg::KIND_LOOKUP, '0, '1, '1);
        send(tbc_pkg::KIND_TRANSLATE, '0, '1, '1);
        send(tbc_pkg::KIND_TRANSLATE, '1, '1, 13'd4096);
        send(tbc_pkg::KIND_LOOKUP, '1, '0, '0);
        send(tbc_pkg::KIND_TRANSLATE, {24{2'b01}}, {24{2'b10}}, 13'd8191);
        send(tbc_pkg::KIND_TRANSLATE, {24{2'b10}}, {24{2'b01}}, 13'd1);
        send(tbc_pkg::KIND_LOOKUP, {24{2'b01}}, '0, '0);
        send(tbc_pkg::KIND_LOOKUP, {24{2'b10}}, '0, '0);
        send(tbc_pkg::KIND_LOOKUP, 48'h1234_5678_9abc, '0, '0);
        send(KIND_UNUSED, '1, '1, '1);
        send(KIND_UNUSED, '0, '0, '0);
        send(tbc_pkg::KIND_FLUSH, '0, '0, '0);
        send(tbc_pkg::KIND_LOOKUP, '1, '0, '0);
        send(tbc_pkg::KIND_TRANSLATE, '1, 48'h0000_dead_beef, 13'd77);
        send(tbc_pkg::KIND_LOOKUP, '1, '0, '0);
        send(tbc_pkg::KIND_FLUSH, '1, '1, '1);

        repeat (250) random_item();
        drain();

        idle_en = 1'b0;
        send(tbc_pkg::KIND_FLUSH, '0, '0, '0);
        send(tbc_pkg::KIND_TRANSLATE, rand_addr(), rand_addr(), 13'd5);
        send(tbc_pkg::KIND_LOOKUP, tracker.tag_mem[tracker.fill_level - 1], '0, '0);
        send(tbc_pkg::KIND_TRANSLATE, tracker.tag_mem[tracker.fill_level - 1], '0, '0);
        send(tbc_pkg::KIND_LOOKUP, tracker.tag_mem[0], '0, '0);
        send(tbc_pkg::KIND_LOOKUP, rand_addr(), '0, '0);
        send(tbc_pkg::KIND_FLUSH, '0, '0, '0);

        repeat (100) random_item();
        idle_en = 1'b1;
        repeat (205) random_item();

        start = 1'b0;
        while (tracker.pending_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_rsps.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
